/* rtl/rebq_pkg.sv */
// shared types and constants for the rotary encoder and button qualifier
`timescale 1ns / 1ps

package rebq_pkg;

    // configuration register width
    localparam int REG_BITS = 22;

    // default elapsed counter width
    localparam int COUNT_BITS_DEF = 22;

    // configuration register indexes
    localparam int CFG_ADDR_BITS = 2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_STARTUP_TICKS  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_EDGE_LOCKOUT   = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_REPORT_INTERVAL = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BUTTON_LOCKOUT = 2'd3;

    // register reset values
    localparam logic [REG_BITS-1:0] STARTUP_TICKS_RST   = 22'd3000000;
    localparam logic [REG_BITS-1:0] EDGE_LOCKOUT_RST    = 22'd100000;
    localparam logic [REG_BITS-1:0] REPORT_INTERVAL_RST = 22'd300000;
    localparam logic [REG_BITS-1:0] BUTTON_LOCKOUT_RST  = 22'd200000;

    // register set handed to the qualifier logic
    typedef struct packed {
        logic [REG_BITS-1:0] startup_ticks;
        logic [REG_BITS-1:0] edge_lockout_ticks;
        logic [REG_BITS-1:0] report_interval_ticks;
        logic [REG_BITS-1:0] button_lockout_ticks;
    } cfg_t;

endpackage

/* rtl/rotary_encoder_button_qualifier_top.sv */
// Qualifies rotary encoder steps and button presses from sampled pin levels,
// one input transfer per tick. Each input transfer produces exactly one
// registered result transfer; a new sample is taken every cycle as long
// as the result register is empty or being drained in the same cycle. The
// single result register and the elapsed counters, each a saturating
// increment and one compare, set this rate. After reset all events are
// blanked for startup_ticks samples; the user writes configuration through
// cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce it.
`timescale 1ns / 1ps

module rotary_encoder_button_qualifier_top
    import rebq_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [REG_BITS-1:0]      cfg_wdata,
    // pin samples
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_clk_level,
    input  logic                     s_dt_level,
    input  logic                     s_sw_level,
    // qualified events
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_rotation_valid,
    output logic                     m_rotation_dir,
    output logic                     m_button_press
);

    localparam int CMP_BITS = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    cfg_t cfg;

    logic                  s_xfer;
    logic                  blanked;
    logic                  edge_ok;
    logic                  report_ok;
    logic                  press_ok;
    logic [COUNT_BITS-1:0] e_edge;
    logic [COUNT_BITS-1:0] e_report;
    logic [COUNT_BITS-1:0] e_press;
    logic [COUNT_BITS-1:0] startup_inc;

    logic                  prev_clk_reg,        prev_clk_next;
    logic                  prev_sw_reg,         prev_sw_next;
    logic                  released_seen_reg,   released_seen_next;
    logic [COUNT_BITS-1:0] startup_elapsed_reg, startup_elapsed_next;
    logic [COUNT_BITS-1:0] since_edge_reg,      since_edge_next;
    logic [COUNT_BITS-1:0] since_report_reg,    since_report_next;
    logic [COUNT_BITS-1:0] since_press_reg,     since_press_next;

    logic                  m_valid_reg,         m_valid_next;
    logic                  rotation_valid_reg,  rotation_valid_next;
    logic                  rotation_dir_reg,    rotation_dir_next;
    logic                  button_press_reg,    button_press_next;

    rebq_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // take a sample whenever the result register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    // saturating elapsed counts for this tick
    assign e_edge      = (since_edge_reg == CNT_MAX) ? CNT_MAX : since_edge_reg + 1'b1;
    assign e_report    = (since_report_reg == CNT_MAX) ? CNT_MAX : since_report_reg + 1'b1;
    assign e_press     = (since_press_reg == CNT_MAX) ? CNT_MAX : since_press_reg + 1'b1;
    assign startup_inc = (startup_elapsed_reg == CNT_MAX) ? CNT_MAX
                                                          : startup_elapsed_reg + 1'b1;

    // qualification compares at the common width
    assign blanked   = CMP_BITS'(startup_elapsed_reg) < CMP_BITS'(cfg.startup_ticks);
    assign edge_ok   = !blanked && prev_clk_reg && !s_clk_level
                       && (CMP_BITS'(e_edge) >= CMP_BITS'(cfg.edge_lockout_ticks));
    assign report_ok = CMP_BITS'(e_report) >= CMP_BITS'(cfg.report_interval_ticks);
    assign press_ok  = !blanked && released_seen_reg && prev_sw_reg && !s_sw_level
                       && (CMP_BITS'(e_press) >= CMP_BITS'(cfg.button_lockout_ticks));

    // next state and result on an input transfer
    always_comb begin
        prev_clk_next        = prev_clk_reg;
        prev_sw_next         = prev_sw_reg;
        released_seen_next   = released_seen_reg;
        startup_elapsed_next = startup_elapsed_reg;
        since_edge_next      = since_edge_reg;
        since_report_next    = since_report_reg;
        since_press_next     = since_press_reg;
        rotation_valid_next  = rotation_valid_reg;
        rotation_dir_next    = rotation_dir_reg;
        button_press_next    = button_press_reg;
        m_valid_next         = m_valid_reg && !m_ready;
        if (s_xfer) begin
            m_valid_next         = 1'b1;
            prev_clk_next        = s_clk_level;
            prev_sw_next         = s_sw_level;
            released_seen_next   = released_seen_reg || s_sw_level;
            startup_elapsed_next = startup_inc;
            since_edge_next      = edge_ok ? '0 : e_edge;
            since_report_next    = (edge_ok && report_ok) ? '0 : e_report;
            since_press_next     = press_ok ? '0 : e_press;
            rotation_valid_next  = edge_ok && report_ok;
            rotation_dir_next    = edge_ok && report_ok && s_dt_level;
            button_press_next    = press_ok;
        end
    end

    // control and counter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_clk_reg        <= 1'b1;
            prev_sw_reg         <= 1'b1;
            released_seen_reg   <= 1'b0;
            startup_elapsed_reg <= '0;
            since_edge_reg      <= CNT_MAX;
            since_report_reg    <= CNT_MAX;
            since_press_reg     <= CNT_MAX;
            m_valid_reg         <= 1'b0;
        end else begin
            prev_clk_reg        <= prev_clk_next;
            prev_sw_reg         <= prev_sw_next;
            released_seen_reg   <= released_seen_next;
            startup_elapsed_reg <= startup_elapsed_next;
            since_edge_reg      <= since_edge_next;
            since_report_reg    <= since_report_next;
            since_press_reg     <= since_press_next;
            m_valid_reg         <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        rotation_valid_reg <= rotation_valid_next;
        rotation_dir_reg   <= rotation_dir_next;
        button_press_reg   <= button_press_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_rotation_valid = rotation_valid_reg;
    assign m_rotation_dir   = rotation_dir_reg;
    assign m_button_press   = button_press_reg;

`ifndef ASSERT_OFF
    // direction is only set on a reported step
    a_cw_needs_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !rotation_valid_reg) |-> !rotation_dir_reg)
        else $error("direction set without a reported step");

    // blanked samples never produce events
    a_blank_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && blanked) |=> (!rotation_valid_reg && !button_press_reg))
        else $error("event reported during startup blanking");

    // a reported step restarts both rotation counters
    a_step_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && edge_ok && report_ok) |=> (since_report_reg == '0 && since_edge_reg == '0))
        else $error("reported step did not restart counters");

    // input only stalls while a result is held
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready))
        else $error("input stalled with no held result");
`endif

endmodule

/* rtl/rebq_cfg_regs.sv */
// configuration register file for the encoder and button qualifier
`timescale 1ns / 1ps

module rebq_cfg_regs
    import rebq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [REG_BITS-1:0]      cfg_wdata,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // address decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_STARTUP_TICKS:   cfg_next.startup_ticks         = cfg_wdata;
                CFG_EDGE_LOCKOUT:    cfg_next.edge_lockout_ticks    = cfg_wdata;
                CFG_REPORT_INTERVAL: cfg_next.report_interval_ticks = cfg_wdata;
                CFG_BUTTON_LOCKOUT:  cfg_next.button_lockout_ticks  = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.startup_ticks         <= STARTUP_TICKS_RST;
            cfg_reg.edge_lockout_ticks    <= EDGE_LOCKOUT_RST;
            cfg_reg.report_interval_ticks <= REPORT_INTERVAL_RST;
            cfg_reg.button_lockout_ticks  <= BUTTON_LOCKOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* tb/tb_rotary_encoder_button_qualifier_top.sv */
// self-checking testbench for the rotary encoder and button qualifier
`timescale 1ns / 1ps

module tb_rotary_encoder_button_qualifier_top
    import rebq_pkg::*;
();

    localparam int CNT_W = COUNT_BITS_DEF;
    localparam logic [REG_BITS-1:0] REG_MAX = {REG_BITS{1'b1}};
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 120;
    localparam int PHASE_ITEMS = 90;

    // one qualified event result
    typedef struct packed {
        logic rot_valid;
        logic rot_cw;
        logic press;
    } qual_event_t;

    localparam qual_event_t QUIET = '0;
    localparam qual_event_t STEP_CW = '{rot_valid: 1'b1, rot_cw: 1'b1, press: 1'b0};

    // one row of the directed plan: a register write or a pin sample
    typedef struct packed {
        logic                     is_cfg;
        logic [CFG_ADDR_BITS-1:0] addr;
        logic [REG_BITS-1:0]      data;
        logic                     clk_l;
        logic                     dt_l;
        logic                     sw_l;
        logic                     typed;
        qual_event_t              res;
    } step_row_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [REG_BITS-1:0]      cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_clk_level = 1'b1;
    logic                     s_dt_level = 1'b0;
    logic                     s_sw_level = 1'b1;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_rotation_valid;
    logic                     m_rotation_dir;
    logic                     m_button_press;

    // hand-typed expectation travelling with the offered sample
    logic        offer_typed = 1'b0;
    qual_event_t offer_event = '0;

    // qualifier model: registers and state
    logic [REG_BITS-1:0] blank_len = STARTUP_TICKS_RST;
    logic [REG_BITS-1:0] edge_gap = EDGE_LOCKOUT_RST;
    logic [REG_BITS-1:0] report_gap = REPORT_INTERVAL_RST;
    logic [REG_BITS-1:0] press_gap = BUTTON_LOCKOUT_RST;
    logic                last_clk = 1'b1;
    logic                last_sw = 1'b1;
    logic                sw_released = 1'b0;
    logic [CNT_W-1:0]    boot_count = '0;
    logic [CNT_W-1:0]    edge_age = '1;
    logic [CNT_W-1:0]    report_age = '1;
    logic [CNT_W-1:0]    press_age = '1;

    qual_event_t pending_events[$];
    step_row_t   plan[$];
    int          items_sent = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    logic        gen_clk = 1'b1;
    logic        gen_sw = 1'b1;

    rotary_encoder_button_qualifier_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_clk_level      (s_clk_level),
        .s_dt_level       (s_dt_level),
        .s_sw_level       (s_sw_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rotation_valid (m_rotation_valid),
        .m_rotation_dir   (m_rotation_dir),
        .m_button_press   (m_button_press)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rotary_encoder_button_qualifier_top regression: fail");
            $finish;
        end
    end

    function automatic logic [CNT_W-1:0] sat_step(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // advance the qualifier model by one tick and return its event
    function automatic qual_event_t qualify_sample(logic clk_l, logic dt_l, logic sw_l);
        logic             blanked;
        logic [CNT_W-1:0] e_edge;
        logic [CNT_W-1:0] e_rep;
        logic [CNT_W-1:0] e_press;
        qual_event_t      ev;
        ev = QUIET;
        blanked = (boot_count < blank_len);
        e_edge = sat_step(edge_age);
        e_rep = sat_step(report_age);
        e_press = sat_step(press_age);
        if (sw_l)
            sw_released = 1'b1;
        // falling clk edge past the lockout, reported only past the interval
        if (!blanked && last_clk && !clk_l && e_edge >= edge_gap) begin
            e_edge = '0;
            if (e_rep >= report_gap) begin
                e_rep = '0;
                ev.rot_valid = 1'b1;
                ev.rot_cw = dt_l;
            end
        end
        // falling sw edge once released, past the button lockout
        if (!blanked && sw_released && last_sw && !sw_l && e_press >= press_gap) begin
            e_press = '0;
            ev.press = 1'b1;
        end
        edge_age = e_edge;
        report_age = e_rep;
        press_age = e_press;
        boot_count = sat_step(boot_count);
        last_clk = clk_l;
        last_sw = sw_l;
        return ev;
    endfunction

    task automatic note_mismatch(string what);
        if (mismatches < 60)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // input transfer: predict and queue the expected event
    always @(posedge aclk) begin
        qual_event_t ev;
        if (aresetn && s_valid && s_ready) begin
            ev = qualify_sample(s_clk_level, s_dt_level, s_sw_level);
            if (offer_typed)
                ev = offer_event;
            pending_events.push_back(ev);
        end
    end

    // result transfer: compare with the oldest expectation
    always @(posedge aclk) begin
        qual_event_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_events.size() == 0) begin
                note_mismatch("result transfer with nothing expected");
            end else begin
                want = pending_events.pop_front();
                if (m_rotation_valid !== want.rot_valid)
                    note_mismatch($sformatf("rotation_valid %b, expected %b",
                                            m_rotation_valid, want.rot_valid));
                if (m_rotation_dir !== want.rot_cw)
                    note_mismatch($sformatf("rotation_dir %b, expected %b",
                                            m_rotation_dir, want.rot_cw));
                if (m_button_press !== want.press)
                    note_mismatch($sformatf("button_press %b, expected %b",
                                            m_button_press, want.press));
            end
        end
    end

    // result side ready: random stalls plus an occasional long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic step_row_t reg_row(logic [CFG_ADDR_BITS-1:0] idx,
                                          logic [REG_BITS-1:0] val);
        step_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.addr = idx;
        r.data = val;
        return r;
    endfunction

    function automatic step_row_t pin_row(logic c, logic d, logic s);
        step_row_t r;
        r = '0;
        r.clk_l = c;
        r.dt_l = d;
        r.sw_l = s;
        return r;
    endfunction

    function automatic step_row_t pin_row_exp(logic c, logic d, logic s, qual_event_t ev);
        step_row_t r;
        r = pin_row(c, d, s);
        r.typed = 1'b1;
        r.res = ev;
        return r;
    endfunction

    // offer one sample; valid stays high until the transfer
    task automatic offer_sample(logic c, logic d, logic s, logic typed, qual_event_t ev);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_clk_level <= c;
        s_dt_level <= d;
        s_sw_level <= s;
        offer_typed <= typed;
        offer_event <= ev;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
    endtask

    // encoder-like pin activity with some noise
    task automatic offer_random_sample();
        logic d;
        d = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 12) begin
            gen_clk = 1'($urandom_range(0, 1));
            gen_sw = 1'($urandom_range(0, 1));
        end else begin
            if ($urandom_range(0, 99) < 35)
                gen_clk = !gen_clk;
            if ($urandom_range(0, 99) < 20)
                gen_sw = !gen_sw;
        end
        offer_sample(gen_clk, d, gen_sw, 1'b0, QUIET);
    endtask

    // drop valid and wait for every expected result
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_seen < items_sent)
            @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [REG_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_STARTUP_TICKS:   blank_len = val;
            CFG_EDGE_LOCKOUT:    edge_gap = val;
            CFG_REPORT_INTERVAL: report_gap = val;
            CFG_BUTTON_LOCKOUT:  press_gap = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        step_row_t           row;
        int                  phase;
        logic [REG_BITS-1:0] blank_val;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed plan
        plan = '{
            reg_row(CFG_STARTUP_TICKS, '0),
            reg_row(CFG_EDGE_LOCKOUT, 22'd2),
            reg_row(CFG_REPORT_INTERVAL, 22'd4),
            reg_row(CFG_BUTTON_LOCKOUT, 22'd3),
            // first edge sees saturated counters; press before any release
            pin_row_exp(1'b0, 1'b1, 1'b0, STEP_CW),
            pin_row(1'b1, 1'b0, 1'b1),
            // edge past lockout but inside the report interval
            pin_row(1'b0, 1'b0, 1'b0),
            pin_row(1'b1, 1'b1, 1'b1),
            pin_row(1'b0, 1'b1, 1'b0),
            pin_row(1'b1, 1'b0, 1'b1),
            pin_row(1'b0, 1'b0, 1'b0),
            // zero lockouts: every edge counts
            reg_row(CFG_EDGE_LOCKOUT, '0),
            reg_row(CFG_REPORT_INTERVAL, '0),
            reg_row(CFG_BUTTON_LOCKOUT, '0),
            pin_row(1'b1, 1'b1, 1'b1),
            pin_row(1'b0, 1'b1, 1'b0),
            pin_row(1'b1, 1'b0, 1'b1),
            pin_row(1'b0, 1'b0, 1'b0),
            pin_row(1'b0, 1'b1, 1'b0),
            // blanking: pins still tracked
            reg_row(CFG_STARTUP_TICKS, REG_MAX),
            pin_row_exp(1'b1, 1'b1, 1'b1, QUIET),
            pin_row_exp(1'b0, 1'b1, 1'b0, QUIET),
            reg_row(CFG_STARTUP_TICKS, '0),
            pin_row(1'b0, 1'b0, 1'b0),
            // full-scale lockouts
            reg_row(CFG_EDGE_LOCKOUT, REG_MAX),
            reg_row(CFG_REPORT_INTERVAL, REG_MAX),
            reg_row(CFG_BUTTON_LOCKOUT, REG_MAX),
            pin_row_exp(1'b1, 1'b1, 1'b1, QUIET),
            pin_row_exp(1'b0, 1'b1, 1'b0, QUIET),
            pin_row_exp(1'b1, 1'b0, 1'b1, QUIET),
            pin_row_exp(1'b0, 1'b0, 1'b0, QUIET),
            // edge accepted but dropped by the report interval
            reg_row(CFG_EDGE_LOCKOUT, '0),
            pin_row_exp(1'b1, 1'b1, 1'b1, QUIET),
            pin_row_exp(1'b0, 1'b1, 1'b1, QUIET)
        };

        send_idle_pct = 35;
        recv_idle_pct = 73;
        foreach (plan[n]) begin
            row = plan[n];
            if (row.is_cfg) begin
                wait_idle();
                write_reg(row.addr, row.data);
            end else begin
                offer_sample(row.clk_l, row.dt_l, row.sw_l, row.typed, row.res);
            end
        end

        // random phases, each with fresh register settings
        for (phase = 0; phase < 9; phase++) begin
            send_idle_pct = (phase < 3) ? 35 : (phase < 6) ? 73 : 0;
            recv_idle_pct = (phase < 3) ? 73 : (phase < 6) ? 35 : 0;
            wait_idle();
            blank_val = '0;
            if (phase % 3 == 1)
                blank_val = REG_BITS'(boot_count + $urandom_range(4, 40));
            write_reg(CFG_STARTUP_TICKS, blank_val);
            write_reg(CFG_EDGE_LOCKOUT, (phase == 2) ? '0 : REG_BITS'($urandom_range(0, 10)));
            write_reg(CFG_REPORT_INTERVAL,
                      (phase == 2) ? '0 : REG_BITS'($urandom_range(0, 30)));
            write_reg(CFG_BUTTON_LOCKOUT,
                      (phase == 2) ? '0 : REG_BITS'($urandom_range(0, 25)));
            // long result-side hold while samples keep coming
            if (phase == 6)
                hold_requests++;
            repeat (PHASE_ITEMS) offer_random_sample();
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (pending_events.size() != 0)
            note_mismatch($sformatf("%0d expected results never arrived",
                                    pending_events.size()));
        if (mismatches == 0)
            $display("rotary_encoder_button_qualifier_top regression: pass");
        else
            $display("rotary_encoder_button_qualifier_top regression: fail");
        $finish;
    end

endmodule
